FILE: rtl/strided_index_to_offset_assert.svh
// Assertion macros used by the checker file.
`ifndef STRIDED_INDEX_TO_OFFSET_ASSERT_SVH
`define STRIDED_INDEX_TO_OFFSET_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SITO_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SITO_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SITO_ASSERT_RST(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sito_pkg.sv
`default_nettype none
package sito_pkg;
  localparam int DIM_FIELDS = 4;
  localparam int IDX_W      = 32;
  localparam int SIZE_W     = 16;
  localparam int STRIDE_W   = 16;
  localparam int NDIM_W     = 3;
  localparam int OFS_W      = 36;
  localparam int MAX_DIMS_DEF = 4;

  // One word in flight through the cell chain.
  typedef struct packed {
    logic                                 valid;
    logic [IDX_W-1:0]                     quo;    // dividend shifting into quotient
    logic [SIZE_W-1:0]                    rem;
    logic signed [OFS_W-1:0]              acc;
    logic [NDIM_W-1:0]                    ndims;
    logic [DIM_FIELDS-1:0][SIZE_W-1:0]    sizes;
    logic [DIM_FIELDS-1:0][STRIDE_W-1:0]  strides;
  } word_t;
endpackage
`default_nettype wire

FILE: rtl/sito_div_cell.sv
`default_nettype none
module sito_div_cell import sito_pkg::*; #(
  parameter int DIM = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  word_t din,
  output word_t dout
);
  logic              active;
  logic [SIZE_W-1:0] divisor;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W-1:0] diff;
  logic              take;
  word_t             dnext;

  // diff only matters when take is set; then it is below the divisor.
  always_comb begin
    active  = din.ndims > NDIM_W'(DIM);
    divisor = (active && din.sizes[DIM] != '0) ? din.sizes[DIM] : SIZE_W'(1);
    trial   = {din.rem, din.quo[IDX_W-1]};
    diff    = trial[SIZE_W-1:0] - divisor;
    take    = trial >= {1'b0, divisor};
    dnext   = din;
    dnext.rem = take ? diff : trial[SIZE_W-1:0];
    dnext.quo = {din.quo[IDX_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.quo     <= dnext.quo;
      dout.rem     <= dnext.rem;
      dout.acc     <= dnext.acc;
      dout.ndims   <= dnext.ndims;
      dout.sizes   <= dnext.sizes;
      dout.strides <= dnext.strides;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sito_mac_cell.sv
`default_nettype none
module sito_mac_cell import sito_pkg::*; #(
  parameter int DIM = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  word_t din,
  output word_t dout
);
  logic signed [STRIDE_W-1:0] stride;
  logic signed [SIZE_W+STRIDE_W:0] prod;
  word_t dnext;

  // Unused dimension leaves rem at zero, so its product is zero.
  always_comb begin
    stride = $signed(din.strides[DIM]);
    prod   = $signed({1'b0, din.rem}) * stride;
    dnext  = din;
    dnext.acc = din.acc + {{(OFS_W-SIZE_W-STRIDE_W-1){prod[SIZE_W+STRIDE_W]}}, prod};
    dnext.rem = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.quo     <= dnext.quo;
      dout.rem     <= dnext.rem;
      dout.acc     <= dnext.acc;
      dout.ndims   <= dnext.ndims;
      dout.sizes   <= dnext.sizes;
      dout.strides <= dnext.strides;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/strided_index_to_offset.sv
// Strided array offset generator.
// Input channel (in_valid/in_ready) carries one word: a linear index, a
// dimension count and four size/stride pairs, outermost dimension first.
// Output channel (out_valid/out_ready) returns one signed offset per word.
// Structure: an entry register, then per dimension 32 restoring-division
// cells and one multiply-accumulate cell.
// Throughput: one word per cycle; every cell advances each cycle the chain
// moves, so words follow back to back.
// The chain moves whenever the output register is empty or being taken;
// while the receiver stalls with a word waiting, the whole chain holds and
// in_ready is low. Bubbles travel with the words and are never squeezed out.
// Reset clears all valid flags; no word is in flight afterward.
// Dimensions are handled innermost first. A dimension beyond the count, or
// of size zero, divides by one, which leaves the index unchanged and adds 0.
`default_nettype none
module strided_index_to_offset import sito_pkg::*; #(
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [IDX_W-1:0]           linear_index,
  input  logic [NDIM_W-1:0]          num_dims,
  input  logic [SIZE_W-1:0]          dim_size_0,
  input  logic [SIZE_W-1:0]          dim_size_1,
  input  logic [SIZE_W-1:0]          dim_size_2,
  input  logic [SIZE_W-1:0]          dim_size_3,
  input  logic signed [STRIDE_W-1:0] dim_stride_0,
  input  logic signed [STRIDE_W-1:0] dim_stride_1,
  input  logic signed [STRIDE_W-1:0] dim_stride_2,
  input  logic signed [STRIDE_W-1:0] dim_stride_3,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OFS_W-1:0]    element_offset
);
  localparam int GRP = IDX_W + 1;     // cells per dimension
  localparam int NS  = MAX_DIMS * GRP;

  word_t stage [0:NS];
  logic  en;
  word_t entry_next;

  // Chain advances when the output slot is free or draining.
  assign en       = !stage[NS].valid || out_ready;
  assign in_ready = en;

  always_comb begin
    entry_next.valid   = in_valid;
    entry_next.quo     = linear_index;
    entry_next.rem     = '0;
    entry_next.acc     = '0;
    entry_next.ndims   = (num_dims > NDIM_W'(MAX_DIMS)) ? NDIM_W'(MAX_DIMS) : num_dims;
    entry_next.sizes   = {dim_size_3, dim_size_2, dim_size_1, dim_size_0};
    entry_next.strides = {dim_stride_3, dim_stride_2, dim_stride_1, dim_stride_0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage[0].valid <= 1'b0;
    end else if (en) begin
      stage[0].valid <= entry_next.valid;
    end
    if (en) begin
      stage[0].quo     <= entry_next.quo;
      stage[0].rem     <= entry_next.rem;
      stage[0].acc     <= entry_next.acc;
      stage[0].ndims   <= entry_next.ndims;
      stage[0].sizes   <= entry_next.sizes;
      stage[0].strides <= entry_next.strides;
    end
  end

  // Group g works on dimension MAX_DIMS-1-g: innermost first.
  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_dim
    for (genvar k = 0; k < IDX_W; k++) begin : g_div
      sito_div_cell #(.DIM(MAX_DIMS - 1 - g)) u_div (
        .clk  (clk),
        .rst  (rst),
        .en   (en),
        .din  (stage[g*GRP + k]),
        .dout (stage[g*GRP + k + 1])
      );
    end
    sito_mac_cell #(.DIM(MAX_DIMS - 1 - g)) u_mac (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (stage[g*GRP + IDX_W]),
      .dout (stage[g*GRP + GRP])
    );
  end

  assign out_valid      = stage[NS].valid;
  assign element_offset = stage[NS].acc;
endmodule
`default_nettype wire

FILE: rtl/sito_checker.sv
`default_nettype none
`include "strided_index_to_offset_assert.svh"
module sito_checker import sito_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_ready,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [OFS_W-1:0] element_offset
);
  `SITO_ASSERT_RST(a_rst_empty, clk, rst, !out_valid, "out_valid after reset")
  `SITO_ASSERT_IMP(a_empty_ready, clk, rst, !out_valid, in_ready, "stall with empty output")
  `SITO_ASSERT_IMP(a_stall_block, clk, rst, out_valid && !out_ready, !in_ready,
                   "input taken while output stalled")
  `SITO_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(element_offset), "stalled output changed")
endmodule

bind strided_index_to_offset sito_checker u_sito_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .element_offset (element_offset)
);
`default_nettype wire
